// ===== rtl/jmas_pkg.sv =====
// ----------------------------------------------------------------------------
// jmas_pkg
// Shared types and constants of the joint motion average speed unit.
// ----------------------------------------------------------------------------
package jmas_pkg;

  localparam int COORD_W   = 16;
  localparam int HIST_W    = 8;
  localparam int ERR_W     = 17;
  localparam int SPIKE_W   = 24;
  localparam int SCALE_W   = 16;
  localparam int SPEED_W   = 24;
  localparam int SUM_W     = 27;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int IN_DATA_W = 104;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  // sum of three squares padded to an even width, root two bits per cycle
  localparam int RAD_W       = 36;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int RREM_W      = ROOT_W + 4;
  localparam int ROOT_CYCLES = RAD_W / 4;
  localparam int SQ_TERMS    = 3;

  // mean numerator is (sum * scale) >> 8
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = SUM_W + SCALE_W;
  localparam int NUM_W     = PROD_W - FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HISTORY   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE_Q8 = 2'd3;

  localparam logic [ERR_W-1:0]   RST_ERR_LIMIT     = 17'd10000;
  localparam logic [SPIKE_W-1:0] RST_SPIKE_LIMIT   = 24'd6000;
  localparam logic [HIST_W-1:0]  RST_MIN_HISTORY   = 8'd5;
  localparam logic [SCALE_W-1:0] RST_RATE_SCALE_Q8 = 16'd256;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [ERR_W-1:0]   err_limit;
    logic [SPIKE_W-1:0] spike_limit;
    logic [HIST_W-1:0]  min_history;
    logic [SCALE_W-1:0] rate_scale_q8;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       sq;
    logic [1:0] sq_idx;
    logic       root;
    logic       accum;
    logic       mul;
    logic       div;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic qualify;
    logic eop;
    logic count_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/joint_motion_average_speed_unit.sv =====
// ----------------------------------------------------------------------------
// joint_motion_average_speed_unit
// Average joint displacement per pass, scaled to a speed, spike filtered.
// ----------------------------------------------------------------------------
// Input beats (s_*) carry one tracked joint; s_tlast marks the last joint of
// a pass. Only the last beat of a pass yields an output beat (m_*) with the
// speed and two flags. Registers are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while the unit is idle, the block
// itself does not enforce it.
// For each joint the sequencer loads it; a joint that fails the confidence
// or history check goes straight to the accumulate step and is not counted,
// others pass through the three squares, the two-bit-per-cycle root and the
// accumulate step. The last joint of a pass adds a multiply and the
// bit-serial divide (skipped when no joint counted), then loads the output
// register once the output slot is free.
// The output register frees the input side: while a beat waits on m_tready
// further joints are taken; only the next end of pass waits for the slot.
// Reset (synchronous) restores register defaults, clears sum, count and
// held speed and drops m_tvalid.
// ----------------------------------------------------------------------------
module joint_motion_average_speed_unit import jmas_pkg::*; #(
  parameter int MAX_JOINTS_PER_PASS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // old_x, old_y, old_z, new_x, new_y, new_z, history_length
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // old_confident, new_confident
  input  logic [IN_USER_W-1:0]  s_tuser,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // speed
  output logic [OUT_DATA_W-1:0] m_tdata,
  // spike_rejected, no_joints
  output logic [OUT_USER_W-1:0] m_tuser
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.err_limit     <= RST_ERR_LIMIT;
      cfg.spike_limit   <= RST_SPIKE_LIMIT;
      cfg.min_history   <= RST_MIN_HISTORY;
      cfg.rate_scale_q8 <= RST_RATE_SCALE_Q8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ERR_LIMIT:     cfg.err_limit     <= cfg_data[ERR_W-1:0];
        REG_SPIKE_LIMIT:   cfg.spike_limit   <= cfg_data[SPIKE_W-1:0];
        REG_MIN_HISTORY:   cfg.min_history   <= cfg_data[HIST_W-1:0];
        REG_RATE_SCALE_Q8: cfg.rate_scale_q8 <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  jmas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  jmas_datapath #(
    .MAX_JOINTS_PER_PASS (MAX_JOINTS_PER_PASS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a joint is in progress");

  a_no_joints_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
    else $error("empty pass reported a speed or a spike");

  a_emit_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without end-of-pass work");
`endif

endmodule

// ===== rtl/jmas_ctrl.sv =====
// ----------------------------------------------------------------------------
// jmas_ctrl
// Sequencer: squares, iterative root, accumulate, end-of-pass multiply and divide, and output load.
// ----------------------------------------------------------------------------
module jmas_ctrl import jmas_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [6:0] {
    IDLE = 7'b0000001,
    SQ   = 7'b0000010,
    ROOT = 7'b0000100,
    ACC  = 7'b0001000,
    MUL  = 7'b0010000,
    DIV  = 7'b0100000,
    EMIT = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign in_ready = (state == IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = SQ;
        end
      end
      SQ: begin
        if (!sts.qualify) begin
          state_next = ACC;
        end else begin
          cmd.sq     = 1'b1;
          cmd.sq_idx = step[1:0];
          if (step == STEP_W'(SQ_TERMS - 1)) begin
            step_next  = '0;
            state_next = ROOT;
          end else begin
            step_next = step + 1'b1;
          end
        end
      end
      ROOT: begin
        cmd.root = 1'b1;
        if (step == STEP_W'(ROOT_CYCLES - 1)) begin
          step_next  = '0;
          state_next = ACC;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ACC: begin
        cmd.accum  = 1'b1;
        state_next = sts.eop ? MUL : IDLE;
      end
      MUL: begin
        cmd.mul    = 1'b1;
        step_next  = '0;
        state_next = sts.count_zero ? EMIT : DIV;
      end
      DIV: begin
        cmd.div = 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          step_next  = '0;
          state_next = EMIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
        step_next  = '0;
      end
    endcase
  end

endmodule

// ===== rtl/jmas_datapath.sv =====
// ----------------------------------------------------------------------------
// jmas_datapath
// Displacement, square root, running sum, mean divide, spike filter, output.
// ----------------------------------------------------------------------------
module jmas_datapath import jmas_pkg::*; #(
  parameter int MAX_JOINTS_PER_PASS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic [IN_USER_W-1:0]  in_user,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic [OUT_USER_W-1:0] out_user
);

  localparam int CNT_W = $clog2(MAX_JOINTS_PER_PASS + 1);

  logic [COORD_W-1:0] mag_x, mag_y, mag_z;
  logic               qualify, eop;
  logic [RAD_W-1:0]   acc;
  logic [RREM_W-1:0]  rrem;
  logic [ROOT_W-1:0]  root;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   count;
  logic [NUM_W-1:0]   num;
  logic [CNT_W-1:0]   drem;
  logic [SPEED_W-1:0] held;
  logic [SPEED_W-1:0] out_speed;
  logic               out_spike, out_none;

  function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    logic        [COORD_W:0] m;
    d = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
    m = d[COORD_W] ? -d : d;
    return m[COORD_W-1:0];
  endfunction

  // square term
  logic [COORD_W-1:0]   sq_in;
  logic [2*COORD_W-1:0] sq;
  always_comb begin
    case (cmd.sq_idx)
      AXIS_X:  sq_in = mag_x;
      AXIS_Y:  sq_in = mag_y;
      AXIS_Z:  sq_in = mag_z;
      default: sq_in = '0;
    endcase
  end
  assign sq = sq_in * sq_in;

  // two restoring root steps per cycle
  logic [RREM_W-1:0] r1, r2, t1, t2, r1s, r2s;
  logic [ROOT_W-1:0] q1, q2;
  always_comb begin
    r1 = {rrem[RREM_W-3:0], acc[RAD_W-1 -: 2]};
    t1 = {2'b00, root, 2'b01};
    if (r1 >= t1) begin
      r1s = r1 - t1;
      q1  = {root[ROOT_W-2:0], 1'b1};
    end else begin
      r1s = r1;
      q1  = {root[ROOT_W-2:0], 1'b0};
    end
    r2 = {r1s[RREM_W-3:0], acc[RAD_W-3 -: 2]};
    t2 = {2'b00, q1, 2'b01};
    if (r2 >= t2) begin
      r2s = r2 - t2;
      q2  = {q1[ROOT_W-2:0], 1'b1};
    end else begin
      r2s = r2;
      q2  = {q1[ROOT_W-2:0], 1'b0};
    end
  end

  // accumulate
  logic           take;
  logic [SUM_W:0] sum_ext;
  assign take = qualify && (root < {1'b0, cfg.err_limit})
                && (count < CNT_W'(MAX_JOINTS_PER_PASS));
  assign sum_ext = {1'b0, sum} + (SUM_W + 1)'(root);

  // mean numerator and one quotient bit per cycle
  logic [PROD_W-1:0] prod;
  logic [CNT_W:0]    dtrial;
  logic              dge;
  assign prod   = sum * cfg.rate_scale_q8;
  assign dtrial = {drem, num[NUM_W-1]};
  assign dge    = dtrial >= {1'b0, count};

  // spike filter
  logic [SPEED_W-1:0] cand, diff;
  logic               accept;
  assign cand   = (|num[NUM_W-1:SPEED_W]) ? {SPEED_W{1'b1}} : num[SPEED_W-1:0];
  assign diff   = (cand > held) ? cand - held : held - cand;
  assign accept = diff < cfg.spike_limit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_x   <= abs_diff(in_data[0*COORD_W +: COORD_W], in_data[3*COORD_W +: COORD_W]);
      mag_y   <= abs_diff(in_data[1*COORD_W +: COORD_W], in_data[4*COORD_W +: COORD_W]);
      mag_z   <= abs_diff(in_data[2*COORD_W +: COORD_W], in_data[5*COORD_W +: COORD_W]);
      qualify <= in_user[0] && in_user[1]
                 && (in_data[6*COORD_W +: HIST_W] >= cfg.min_history);
      eop     <= in_last;
      rrem    <= '0;
      root    <= '0;
    end
    if (cmd.sq) begin
      acc <= ((cmd.sq_idx == AXIS_X) ? '0 : acc) + RAD_W'(sq);
    end
    if (cmd.root) begin
      acc  <= {acc[RAD_W-5:0], 4'b0000};
      rrem <= r2s;
      root <= q2;
    end
    if (cmd.mul) begin
      num  <= prod[PROD_W-1:FRAC_BITS];
      drem <= '0;
    end
    if (cmd.div) begin
      drem <= dge ? CNT_W'(dtrial - {1'b0, count}) : dtrial[CNT_W-1:0];
      num  <= {num[NUM_W-2:0], dge};
    end
    if (cmd.emit) begin
      if (count == '0) begin
        out_speed <= '0;
        out_spike <= 1'b0;
        out_none  <= 1'b1;
      end else begin
        out_speed <= accept ? cand : held;
        out_spike <= !accept;
        out_none  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      count     <= '0;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accum && take) begin
        sum   <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        count <= count + 1'b1;
      end
      if (cmd.emit) begin
        if (count != '0 && accept) begin
          held <= cand;
        end
        sum   <= '0;
        count <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.qualify    = qualify;
  assign sts.eop        = eop;
  assign sts.count_zero = (count == '0);
  assign sts.out_free   = !out_valid || out_ready;

  assign out_data = out_speed;
  assign out_user = {out_none, out_spike};

endmodule
